// ===== hw/rtl/rgbw_enc_pkg.sv =====
// shared types and constants of the rgbw led pulse symbol encoder
package rgbw_enc_pkg;

    localparam int unsigned TICK_W      = 15;
    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned PIXEL_W     = 4 * CHAN_W;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_LOW  = 3'd5;

    localparam logic [TICK_W-1:0] RST_ZERO_HIGH  = 15'd3;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW   = 15'd9;
    localparam logic [TICK_W-1:0] RST_ONE_HIGH   = 15'd9;
    localparam logic [TICK_W-1:0] RST_ONE_LOW    = 15'd3;
    localparam logic [TICK_W-1:0] RST_LATCH_HIGH = 15'd250;
    localparam logic [TICK_W-1:0] RST_LATCH_LOW  = 15'd250;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] one_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] latch_high;
        logic [TICK_W-1:0] latch_low;
    } t_timing;

    typedef struct packed {
        logic [PIXEL_W-1:0] word;
        logic               last_pixel;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DATA,
        BK_LATCH
    } t_back_state;

endpackage

// ===== hw/rtl/rgbw_enc_cfg.sv =====
// timing register file written through the configuration channel
module rgbw_enc_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_we,
    input  logic [rgbw_enc_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [rgbw_enc_pkg::TICK_W-1:0]       i_data,
    output rgbw_enc_pkg::t_timing                 o_timing
);

    rgbw_enc_pkg::t_timing r_timing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.zero_high  <= rgbw_enc_pkg::RST_ZERO_HIGH;
            r_timing.zero_low   <= rgbw_enc_pkg::RST_ZERO_LOW;
            r_timing.one_high   <= rgbw_enc_pkg::RST_ONE_HIGH;
            r_timing.one_low    <= rgbw_enc_pkg::RST_ONE_LOW;
            r_timing.latch_high <= rgbw_enc_pkg::RST_LATCH_HIGH;
            r_timing.latch_low  <= rgbw_enc_pkg::RST_LATCH_LOW;
        end else if (i_we) begin
            unique case (i_index)
                rgbw_enc_pkg::CFG_ZERO_HIGH:  r_timing.zero_high  <= i_data;
                rgbw_enc_pkg::CFG_ZERO_LOW:   r_timing.zero_low   <= i_data;
                rgbw_enc_pkg::CFG_ONE_HIGH:   r_timing.one_high   <= i_data;
                rgbw_enc_pkg::CFG_ONE_LOW:    r_timing.one_low    <= i_data;
                rgbw_enc_pkg::CFG_LATCH_HIGH: r_timing.latch_high <= i_data;
                rgbw_enc_pkg::CFG_LATCH_LOW:  r_timing.latch_low  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_timing = r_timing;

endmodule

// ===== hw/rtl/rgbw_enc_queue.sv =====
// short pixel queue between the accepting front and the symbol back end
module rgbw_enc_queue #(
    parameter int unsigned DEPTH = rgbw_enc_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rgbw_enc_pkg::t_job  i_job,
    input  logic                i_pop,
    output rgbw_enc_pkg::t_job  o_job,
    output logic                o_empty,
    output logic                o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rgbw_enc_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wptr;
    logic [PTR_W-1:0]   n_rptr;
    logic [CNT_W-1:0]   n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_FULL);

endmodule

// ===== hw/rtl/rgbw_enc_back.sv =====
// serializer: one pulse symbol per cycle while pixels are queued, then the latch symbol at frame end
module rgbw_enc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rgbw_enc_pkg::t_timing               i_timing,
    input  rgbw_enc_pkg::t_job                  i_job,
    input  logic                                i_empty,
    output logic                                o_pop,
    output logic                                o_valid,
    output logic [rgbw_enc_pkg::TICK_W-1:0]     o_high_ticks,
    output logic [rgbw_enc_pkg::TICK_W-1:0]     o_low_ticks,
    output logic                                o_is_latch,
    output logic                                o_last_symbol
);

    localparam int unsigned BIT_CNT_W = $clog2(rgbw_enc_pkg::PIXEL_W);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(rgbw_enc_pkg::PIXEL_W - 1);

    rgbw_enc_pkg::t_back_state r_state;
    rgbw_enc_pkg::t_back_state n_state;
    logic [rgbw_enc_pkg::PIXEL_W-1:0] r_word;
    logic [rgbw_enc_pkg::PIXEL_W-1:0] n_word;
    logic [BIT_CNT_W-1:0]             r_cnt;
    logic [BIT_CNT_W-1:0]             n_cnt;
    logic                             r_last_pixel;
    logic                             n_last_pixel;
    logic                             r_valid;
    logic                             n_valid;
    logic [rgbw_enc_pkg::TICK_W-1:0]  r_high;
    logic [rgbw_enc_pkg::TICK_W-1:0]  n_high;
    logic [rgbw_enc_pkg::TICK_W-1:0]  r_low;
    logic [rgbw_enc_pkg::TICK_W-1:0]  n_low;
    logic                             r_is_latch;
    logic                             n_is_latch;
    logic                             r_last_sym;
    logic                             n_last_sym;
    logic                             load_ok;

    always_comb begin
        n_state      = r_state;
        n_word       = r_word;
        n_cnt        = r_cnt;
        n_last_pixel = r_last_pixel;
        n_valid      = 1'b0;
        n_high       = r_high;
        n_low        = r_low;
        n_is_latch   = 1'b0;
        n_last_sym   = 1'b0;
        load_ok      = 1'b0;
        o_pop        = 1'b0;
        unique case (r_state)
            rgbw_enc_pkg::BK_IDLE: begin
                load_ok = 1'b1;
            end
            rgbw_enc_pkg::BK_DATA: begin
                n_valid    = 1'b1;
                n_high     = r_word[rgbw_enc_pkg::PIXEL_W-1] ? i_timing.one_high
                                                              : i_timing.zero_high;
                n_low      = r_word[rgbw_enc_pkg::PIXEL_W-1] ? i_timing.one_low
                                                              : i_timing.zero_low;
                n_last_sym = !r_last_pixel && (r_cnt == BIT_LAST);
                n_word     = {r_word[rgbw_enc_pkg::PIXEL_W-2:0], 1'b0};
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == BIT_LAST) begin
                    if (r_last_pixel) begin
                        n_state = rgbw_enc_pkg::BK_LATCH;
                    end else begin
                        load_ok = 1'b1;
                    end
                end
            end
            rgbw_enc_pkg::BK_LATCH: begin
                n_valid    = 1'b1;
                n_high     = i_timing.latch_high;
                n_low      = i_timing.latch_low;
                n_is_latch = 1'b1;
                n_last_sym = 1'b1;
                load_ok    = 1'b1;
            end
            default: begin
                n_state = rgbw_enc_pkg::BK_IDLE;
            end
        endcase
        if (load_ok) begin
            if (!i_empty) begin
                o_pop        = 1'b1;
                n_word       = i_job.word;
                n_last_pixel = i_job.last_pixel;
                n_cnt        = '0;
                n_state      = rgbw_enc_pkg::BK_DATA;
            end else begin
                n_state = rgbw_enc_pkg::BK_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgbw_enc_pkg::BK_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word       <= n_word;
        r_cnt        <= n_cnt;
        r_last_pixel <= n_last_pixel;
        r_high       <= n_high;
        r_low        <= n_low;
        r_is_latch   <= n_is_latch;
        r_last_sym   <= n_last_sym;
    end

    assign o_valid       = r_valid;
    assign o_high_ticks  = r_high;
    assign o_low_ticks   = r_low;
    assign o_is_latch    = r_is_latch;
    assign o_last_symbol = r_last_sym;

endmodule

// ===== hw/rtl/rgbw_led_pulse_symbol_encoder.sv =====
// top level of the rgbw led pulse symbol encoder
// A pixel is taken when i_start is high and o_busy is low; it yields 32 pulse symbols,
// green, red, blue, white, each byte msb first, plus a latch symbol when i_last_pixel is set.
// Symbols leave one per cycle while pixels are queued, each marked by o_valid for exactly
// one cycle; a small pixel queue in front of the serializer lets new pixels be taken while
// the previous one is still being sent, and o_busy rises only when that queue is full. From
// idle, the first symbol passes queue, serializer and output registers. Timing registers are
// written through i_cfg_valid/o_cfg_ready only while idle; the block leaves that to the user.
module rgbw_led_pulse_symbol_encoder #(
    parameter int unsigned QUEUE_DEPTH = rgbw_enc_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [rgbw_enc_pkg::CHAN_W-1:0]     i_red,
    input  logic [rgbw_enc_pkg::CHAN_W-1:0]     i_green,
    input  logic [rgbw_enc_pkg::CHAN_W-1:0]     i_blue,
    input  logic [rgbw_enc_pkg::CHAN_W-1:0]     i_white,
    input  logic                                i_last_pixel,
    output logic                                o_valid,
    output logic [rgbw_enc_pkg::TICK_W-1:0]     o_high_ticks,
    output logic [rgbw_enc_pkg::TICK_W-1:0]     o_low_ticks,
    output logic                                o_is_latch,
    output logic                                o_last_symbol,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rgbw_enc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rgbw_enc_pkg::TICK_W-1:0]     i_cfg_data
);

    rgbw_enc_pkg::t_timing timing;
    rgbw_enc_pkg::t_job    in_job;
    rgbw_enc_pkg::t_job    head_job;
    logic                  push;
    logic                  pop;
    logic                  q_empty;
    logic                  q_full;

    assign o_cfg_ready = 1'b1;

    rgbw_enc_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (i_cfg_valid),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_timing (timing)
    );

    // wire order green, red, blue, white
    assign in_job.word       = {i_green, i_red, i_blue, i_white};
    assign in_job.last_pixel = i_last_pixel;
    assign o_busy            = q_full;
    assign push              = i_start && !q_full;

    rgbw_enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (in_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rgbw_enc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_timing      (timing),
        .i_job         (head_job),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_high_ticks  (o_high_ticks),
        .o_low_ticks   (o_low_ticks),
        .o_is_latch    (o_is_latch),
        .o_last_symbol (o_last_symbol)
    );

endmodule

// ===== dv/rgbw_led_pulse_symbol_encoder_test.sv =====
// testbench of the rgbw led pulse symbol encoder: pixels in, predicted pulse symbols checked
module rgbw_led_pulse_symbol_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbw_enc_pkg::*;

    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_WORDS = 44;

    typedef enum {
        TIMING_KEEP,
        TIMING_RANDOM,
        TIMING_ZERO,
        TIMING_MAX
    } t_timing_plan;

    class pulse_symbol_scoreboard;
        typedef struct packed {
            logic [TICK_W-1:0] high_ticks;
            logic [TICK_W-1:0] low_ticks;
            logic              is_latch;
            logic              last_symbol;
        } t_symbol;

        t_timing     timing;
        t_symbol     expected_symbols[$];
        int unsigned mismatches;

        function new();
            timing = '{zero_high: RST_ZERO_HIGH, zero_low: RST_ZERO_LOW,
                       one_high: RST_ONE_HIGH, one_low: RST_ONE_LOW,
                       latch_high: RST_LATCH_HIGH, latch_low: RST_LATCH_LOW};
            mismatches = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
            case (idx)
                CFG_ZERO_HIGH:  timing.zero_high  = data;
                CFG_ZERO_LOW:   timing.zero_low   = data;
                CFG_ONE_HIGH:   timing.one_high   = data;
                CFG_ONE_LOW:    timing.one_low    = data;
                CFG_LATCH_HIGH: timing.latch_high = data;
                CFG_LATCH_LOW:  timing.latch_low  = data;
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                                 logic [CHAN_W-1:0] blue, logic [CHAN_W-1:0] white,
                                 logic ends_frame);
            logic [PIXEL_W-1:0] word;
            t_symbol            sym;
            // green goes out first, msb first
            word = {green, red, blue, white};
            for (int n = PIXEL_W - 1; n >= 0; n--) begin
                if (word[n]) begin
                    sym.high_ticks = timing.one_high;
                    sym.low_ticks  = timing.one_low;
                end else begin
                    sym.high_ticks = timing.zero_high;
                    sym.low_ticks  = timing.zero_low;
                end
                sym.is_latch    = 1'b0;
                sym.last_symbol = !ends_frame && (n == 0);
                expected_symbols.push_back(sym);
            end
            if (ends_frame) begin
                sym.high_ticks  = timing.latch_high;
                sym.low_ticks   = timing.latch_low;
                sym.is_latch    = 1'b1;
                sym.last_symbol = 1'b1;
                expected_symbols.push_back(sym);
            end
        endfunction

        function void check_symbol(logic [TICK_W-1:0] high_ticks, logic [TICK_W-1:0] low_ticks,
                                   logic is_latch, logic last_symbol);
            t_symbol want;
            if (expected_symbols.size() == 0) begin
                $error("symbol word with no pixel pending: high %0d low %0d",
                       high_ticks, low_ticks);
                mismatches++;
                return;
            end
            want = expected_symbols.pop_front();
            if (high_ticks !== want.high_ticks) begin
                $error("high_ticks: expected %0d, actual %0d", want.high_ticks, high_ticks);
                mismatches++;
            end
            if (low_ticks !== want.low_ticks) begin
                $error("low_ticks: expected %0d, actual %0d", want.low_ticks, low_ticks);
                mismatches++;
            end
            if (is_latch !== want.is_latch) begin
                $error("is_latch: expected %0d, actual %0d", want.is_latch, is_latch);
                mismatches++;
            end
            if (last_symbol !== want.last_symbol) begin
                $error("last_symbol: expected %0d, actual %0d", want.last_symbol, last_symbol);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_start      = 1'b0;
    logic [CHAN_W-1:0]    i_red        = '0;
    logic [CHAN_W-1:0]    i_green      = '0;
    logic [CHAN_W-1:0]    i_blue       = '0;
    logic [CHAN_W-1:0]    i_white      = '0;
    logic                 i_last_pixel = 1'b0;
    logic                 i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [TICK_W-1:0]    i_cfg_data   = '0;
    logic                 o_busy;
    logic                 o_valid;
    logic [TICK_W-1:0]    o_high_ticks;
    logic [TICK_W-1:0]    o_low_ticks;
    logic                 o_is_latch;
    logic                 o_last_symbol;
    logic                 o_cfg_ready;

    int unsigned sender_idle_pct = 0;

    pulse_symbol_scoreboard board = new();

    rgbw_led_pulse_symbol_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_white       (i_white),
        .i_last_pixel  (i_last_pixel),
        .o_valid       (o_valid),
        .o_high_ticks  (o_high_ticks),
        .o_low_ticks   (o_low_ticks),
        .o_is_latch    (o_is_latch),
        .o_last_symbol (o_last_symbol),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            board.check_symbol(o_high_ticks, o_low_ticks, o_is_latch, o_last_symbol);
        end
    end

    task automatic send_pixel(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                              input logic [CHAN_W-1:0] blue, input logic [CHAN_W-1:0] white,
                              input logic ends_frame);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        // now and then let the serializer run dry
        if (sender_idle_pct != 0 && $urandom_range(15) == 0) gap += $urandom_range(48, 1);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_red        <= red;
        i_green      <= green;
        i_blue       <= blue;
        i_white      <= white;
        i_last_pixel <= ends_frame;
        do @(posedge i_clk); while (o_busy);
        board.note_pixel(red, green, blue, white, ends_frame);
    endtask

    task automatic wait_drain();
        i_start <= 1'b0;
        while (board.expected_symbols.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_timing(input t_timing_plan plan);
        logic [TICK_W-1:0] value;
        // spare indexes past the list are written too and must be ignored
        for (int k = int'(CFG_ZERO_HIGH); k < (1 << CFG_IDX_W); k++) begin
            case (plan)
                TIMING_MAX:  value = '1;
                TIMING_ZERO: value = '0;
                default: begin
                    if ($urandom_range(3) == 0) value = TICK_W'($urandom_range(4));
                    else value = TICK_W'($urandom);
                end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(k);
            i_cfg_data  <= value;
            do @(posedge i_clk); while (!o_cfg_ready);
            board.write_register(CFG_IDX_W'(k), value);
        end
        i_cfg_valid <= 1'b0;
    endtask

    logic [PIXEL_W:0] directed_pixels [15] = '{
        {32'h00000000, 1'b0}, {32'hFFFFFFFF, 1'b0}, {32'hFF000000, 1'b0},
        {32'h00FF0000, 1'b0}, {32'h0000FF00, 1'b0}, {32'h000000FF, 1'b1},
        {32'h80000000, 1'b0}, {32'h00000001, 1'b1}, {32'h80808080, 1'b0},
        {32'h01010101, 1'b0}, {32'hAAAAAAAA, 1'b1}, {32'h55555555, 1'b1},
        {32'h00000000, 1'b1}, {32'hFFFFFFFF, 1'b1}, {32'h12345678, 1'b0}
    };

    t_timing_plan phase_plan [PHASES] = '{
        TIMING_KEEP, TIMING_RANDOM, TIMING_ZERO, TIMING_MAX, TIMING_RANDOM, TIMING_RANDOM
    };

    initial begin
        int unsigned stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) stalled = 0;
            else stalled++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        logic [CHAN_W-1:0] chan [4];
        logic              ends_frame;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < PHASES; p++) begin
            sender_idle_pct = (p < 2) ? 31 : (p < 4) ? 75 : 0;
            if (phase_plan[p] != TIMING_KEEP) begin
                wait_drain();
                load_timing(phase_plan[p]);
            end
            if (p == 0) begin
                foreach (directed_pixels[d]) begin
                    send_pixel(directed_pixels[d][24:17], directed_pixels[d][32:25],
                               directed_pixels[d][16:9], directed_pixels[d][8:1],
                               directed_pixels[d][0]);
                end
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                for (int c = 0; c < 4; c++) begin
                    case ($urandom_range(7))
                        0:       chan[c] = '0;
                        1:       chan[c] = '1;
                        default: chan[c] = CHAN_W'($urandom);
                    endcase
                end
                ends_frame = ($urandom_range(3) == 0);
                send_pixel(chan[0], chan[1], chan[2], chan[3], ends_frame);
            end
        end
        wait_drain();
        repeat (40) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_symbols.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
